// ===== rtl/rfls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rfls_pkg;
  localparam int PROJ_W  = 32;
  localparam int ETA_W   = 24;
  localparam int RATIO_W = 24;
  localparam int CNT_W   = 8;
  localparam int TOL_W   = 24;
  localparam int LIM_W   = 23;
  localparam int CFG_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int DIV_W   = 56;
  localparam int DEN_W   = 33;
  localparam int TERM_W  = 43;
  localparam int DCNT_W  = 6;

  localparam logic signed [ETA_W-1:0] ETA_ONE   = ETA_W'(1 << FRAC_W);
  localparam logic [RATIO_W-1:0]      RATIO_MAX = '1;
  localparam logic [DIV_W-1:0]        QUOT_CAP  = DIV_W'(64'd1 << 40);
  localparam logic [CNT_W-1:0]        CNT_MAX   = '1;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_FAIL   = 2'd2;

  localparam logic [1:0] CFG_TOL     = 2'd0;
  localparam logic [1:0] CFG_MAX_IT  = 2'd1;
  localparam logic [1:0] CFG_MIN_ETA = 2'd2;
  localparam logic [1:0] CFG_MAX_ETA = 2'd3;

  typedef enum logic [2:0] {
    ACT_TRIAL     = 3'd0,
    ACT_FINAL     = 3'd1,
    ACT_RESTORE   = 3'd2,
    ACT_UNCHANGED = 3'd3,
    ACT_UPD_ERR   = 3'd4,
    ACT_UNB_ERR   = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BRACKET = 2'd1,
    PH_SECANT  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RLAUNCH, S_RWAIT, S_RATIO, S_CHECK, S_BRACKET,
    S_SECANT, S_SLAUNCH, S_SWAIT, S_SDONE, S_EMIT
  } state_t;

  function automatic logic [PROJ_W-1:0] mag(input logic signed [PROJ_W-1:0] v);
    mag = v[PROJ_W-1] ? PROJ_W'(~v + 1'b1) : PROJ_W'(v);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/rfls_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rfls_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [rfls_pkg::PROJ_W-1:0]  projection_first;
  logic signed [rfls_pkg::PROJ_W-1:0]  projection_full;
  logic                                fail_stage;
  modport source (output valid, func, projection_first, projection_full, fail_stage,
                  input ready);
  modport sink (input valid, func, projection_first, projection_full, fail_stage,
                output ready);
endinterface

interface rfls_out_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          action;
  logic signed [rfls_pkg::ETA_W-1:0]   step_factor;
  logic [rfls_pkg::RATIO_W-1:0]        residual_ratio;
  logic [rfls_pkg::CNT_W-1:0]          iteration;
  modport source (output valid, action, step_factor, residual_ratio, iteration,
                  input ready);
  modport sink (input valid, action, step_factor, residual_ratio, iteration,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/regula_falsi_line_search_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Regula falsi line search sequencer.
// in_if carries one word per event: start (s0, s1), measured projection
// report, or integrator failure. out_if returns at most one word per input
// word: a trial increment or the way the search ended, with the current
// residual ratio and iteration count. cfg_we/cfg_index/cfg_data write the
// tolerance, iteration limit and eta clamps, effective at once.
// A failure passes through the emit state to the output register. A start
// or report runs one 56-bit ratio division on the shared restoring divider;
// a secant step needs a second. The divider gives one quotient bit per cycle.
// One word is worked on at a time; in_if.ready is high only while idle.
// A finished word sits in the output register; the next input word is taken
// while it waits, but a new result waits until out_if takes the old one.
// Reset (rst_n, synchronous) loads the default registers, idles the search
// and empties the output register. Reports while idle give no result.
module regula_falsi_line_search_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rfls_in_if.sink                            in_if,
  rfls_out_if.source                         out_if,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [rfls_pkg::CFG_W-1:0]    cfg_data
);
  localparam int PW = rfls_pkg::PROJ_W;
  localparam int EW = rfls_pkg::ETA_W;
  localparam int TW = rfls_pkg::TERM_W;

  rfls_pkg::state_t state_r, state_nxt;
  rfls_pkg::phase_t phase_r;

  logic [rfls_pkg::TOL_W-1:0]   tol_r;
  logic [rfls_pkg::CNT_W-1:0]   max_it_r;
  logic [rfls_pkg::LIM_W-1:0]   min_eta_r, max_eta_r;

  logic [1:0]                   func_r;
  logic signed [PW-1:0]         a_r;
  logic signed [PW-1:0]         init_proj_r, up_proj_r, lo_proj_r;
  logic [rfls_pkg::RATIO_W-1:0] init_ratio_r, cur_ratio_r;
  logic signed [EW-1:0]         up_eta_r, lo_eta_r, app_eta_r, trial_eta_r, brk_r;
  logic [rfls_pkg::CNT_W-1:0]   step_r;
  rfls_pkg::act_t               act_r;
  logic signed [EW-1:0]         fac_r;
  logic [rfls_pkg::DIV_W-1:0]   prod_r;
  logic [rfls_pkg::DEN_W-1:0]   den_r;
  logic                         neg_r, den_zero_r;

  logic                         out_valid_r;
  logic [2:0]                   out_act_r;
  logic signed [EW-1:0]         out_fac_r;
  logic [rfls_pkg::RATIO_W-1:0] out_ratio_r;
  logic [rfls_pkg::CNT_W-1:0]   out_cnt_r;

  logic                         in_ready, in_fire, div_start, load_out;
  logic [rfls_pkg::DIV_W-1:0]   div_dividend;
  logic [rfls_pkg::DEN_W-1:0]   div_divisor;
  logic                         div_done;
  logic [rfls_pkg::DIV_W-1:0]   div_q;

  logic [rfls_pkg::RATIO_W-1:0] ratio_val;
  logic                         same_sign, can_grow, secant_go, is_start;
  logic signed [EW+1:0]         eta4, grown;
  logic signed [EW:0]           deta;
  logic [EW-1:0]                deta_mag;
  logic [PW-1:0]                mag_up, mag_lo;
  logic [rfls_pkg::DEN_W-1:0]   den_val;
  logic signed [TW-1:0]         term, eta_w;
  logic [TW-1:0]                term_mag;
  logic signed [EW-1:0]         eta_fin;

  rfls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_fire  = in_if.valid && in_ready;
  assign is_start = (func_r == rfls_pkg::FUNC_START);

  always_comb begin
    ratio_val = (div_q > rfls_pkg::DIV_W'(rfls_pkg::RATIO_MAX)) ? rfls_pkg::RATIO_MAX
                : div_q[rfls_pkg::RATIO_W-1:0];
    if (init_proj_r == '0) ratio_val = '0;
    same_sign = (up_proj_r != '0) && (lo_proj_r != '0) &&
                (up_proj_r[PW-1] == lo_proj_r[PW-1]);
    can_grow  = up_eta_r < $signed({1'b0, max_eta_r});
    eta4      = {app_eta_r, 2'b00};
    grown     = (eta4 > $signed({3'b000, max_eta_r})) ? $signed({3'b000, max_eta_r}) : eta4;
    secant_go = (cur_ratio_r > tol_r) && (step_r < max_it_r);
    deta      = {lo_eta_r[EW-1], lo_eta_r} - {up_eta_r[EW-1], up_eta_r};
    deta_mag  = deta[EW] ? EW'(~deta + 1'b1) : deta[EW-1:0];
    mag_up    = rfls_pkg::mag(up_proj_r);
    mag_lo    = rfls_pkg::mag(lo_proj_r);
    if (lo_proj_r[PW-1] != up_proj_r[PW-1]) begin
      den_val = {1'b0, mag_lo} + {1'b0, mag_up};
    end else begin
      den_val = (mag_lo > mag_up) ? {1'b0, mag_lo - mag_up} : {1'b0, mag_up - mag_lo};
    end
    term_mag = (div_q > rfls_pkg::QUOT_CAP) ? TW'(rfls_pkg::QUOT_CAP) : TW'(div_q);
    if (den_zero_r) term_mag = '0;
    term  = neg_r ? -$signed(term_mag) : $signed(term_mag);
    eta_w = TW'(up_eta_r) - term;
    if (eta_w > $signed(TW'(max_eta_r))) eta_w = $signed(TW'(max_eta_r));
    if (cur_ratio_r > init_ratio_r) eta_w = TW'(rfls_pkg::ETA_ONE);
    if (eta_w < $signed(TW'(min_eta_r))) eta_w = $signed(TW'(min_eta_r));
    eta_fin = eta_w[EW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfls_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_if.func == rfls_pkg::FUNC_START) begin
            state_nxt = rfls_pkg::S_RLAUNCH;
          end else if (in_if.func == rfls_pkg::FUNC_FAIL) begin
            state_nxt = rfls_pkg::S_EMIT;
          end else if (in_if.func == rfls_pkg::FUNC_REPORT && phase_r != rfls_pkg::PH_IDLE) begin
            state_nxt = rfls_pkg::S_RLAUNCH;
          end
        end
      end
      rfls_pkg::S_RLAUNCH: state_nxt = rfls_pkg::S_RWAIT;
      rfls_pkg::S_RWAIT:   if (div_done) state_nxt = rfls_pkg::S_RATIO;
      rfls_pkg::S_RATIO:   state_nxt = rfls_pkg::S_CHECK;
      rfls_pkg::S_CHECK: begin
        if (is_start) begin
          state_nxt = (cur_ratio_r <= tol_r || up_proj_r == lo_proj_r) ? rfls_pkg::S_EMIT
                      : rfls_pkg::S_BRACKET;
        end else if (phase_r == rfls_pkg::PH_BRACKET) begin
          state_nxt = (cur_ratio_r < tol_r) ? rfls_pkg::S_EMIT : rfls_pkg::S_BRACKET;
        end else begin
          state_nxt = rfls_pkg::S_SECANT;
        end
      end
      rfls_pkg::S_BRACKET: state_nxt = same_sign ? rfls_pkg::S_EMIT : rfls_pkg::S_SECANT;
      rfls_pkg::S_SECANT:  state_nxt = secant_go ? rfls_pkg::S_SLAUNCH : rfls_pkg::S_EMIT;
      rfls_pkg::S_SLAUNCH: state_nxt = rfls_pkg::S_SWAIT;
      rfls_pkg::S_SWAIT:   if (div_done) state_nxt = rfls_pkg::S_SDONE;
      rfls_pkg::S_SDONE:   state_nxt = rfls_pkg::S_EMIT;
      rfls_pkg::S_EMIT:    if (!out_valid_r || out_if.ready) state_nxt = rfls_pkg::S_IDLE;
      default:             state_nxt = rfls_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    div_dividend = prod_r;
    div_divisor  = den_r;
    unique case (state_r)
      rfls_pkg::S_IDLE:    in_ready = 1'b1;
      rfls_pkg::S_RLAUNCH: begin
        div_start    = 1'b1;
        div_dividend = rfls_pkg::DIV_W'({rfls_pkg::mag(a_r), {rfls_pkg::FRAC_W{1'b0}}});
        div_divisor  = {1'b0, rfls_pkg::mag(init_proj_r)};
      end
      rfls_pkg::S_SLAUNCH: div_start = 1'b1;
      rfls_pkg::S_EMIT:    load_out = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rfls_pkg::S_IDLE;
      phase_r      <= rfls_pkg::PH_IDLE;
      tol_r        <= rfls_pkg::TOL_W'(52429);
      max_it_r     <= rfls_pkg::CNT_W'(10);
      min_eta_r    <= rfls_pkg::LIM_W'(6554);
      max_eta_r    <= rfls_pkg::LIM_W'(655360);
      init_proj_r  <= '0;
      up_proj_r    <= '0;
      lo_proj_r    <= '0;
      init_ratio_r <= '0;
      cur_ratio_r  <= '0;
      up_eta_r     <= rfls_pkg::ETA_ONE;
      app_eta_r    <= rfls_pkg::ETA_ONE;
      trial_eta_r  <= rfls_pkg::ETA_ONE;
      lo_eta_r     <= '0;
      brk_r        <= '0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rfls_pkg::CFG_TOL:     tol_r     <= cfg_data;
          rfls_pkg::CFG_MAX_IT:  max_it_r  <= cfg_data[rfls_pkg::CNT_W-1:0];
          rfls_pkg::CFG_MIN_ETA: min_eta_r <= cfg_data[rfls_pkg::LIM_W-1:0];
          rfls_pkg::CFG_MAX_ETA: max_eta_r <= cfg_data[rfls_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        rfls_pkg::S_IDLE: begin
          if (in_fire && in_if.func == rfls_pkg::FUNC_START) begin
            init_proj_r <= in_if.projection_first;
            step_r      <= '0;
            brk_r       <= '0;
            up_eta_r    <= rfls_pkg::ETA_ONE;
            app_eta_r   <= rfls_pkg::ETA_ONE;
            trial_eta_r <= rfls_pkg::ETA_ONE;
            lo_eta_r    <= '0;
            up_proj_r   <= in_if.projection_full;
            lo_proj_r   <= in_if.projection_first;
          end else if (in_fire && in_if.func == rfls_pkg::FUNC_FAIL) begin
            phase_r <= rfls_pkg::PH_IDLE;
          end
        end
        rfls_pkg::S_RATIO: begin
          cur_ratio_r <= ratio_val;
          if (is_start) begin
            init_ratio_r <= ratio_val;
          end else if (phase_r == rfls_pkg::PH_BRACKET) begin
            up_proj_r <= a_r;
          end else begin
            app_eta_r <= trial_eta_r;
            if (a_r == '0 || up_proj_r == '0) begin
              step_r <= max_it_r;
            end else if (a_r[PW-1] != up_proj_r[PW-1]) begin
              lo_eta_r  <= trial_eta_r;
              lo_proj_r <= a_r;
            end else begin
              up_eta_r  <= trial_eta_r;
              up_proj_r <= a_r;
            end
          end
        end
        rfls_pkg::S_CHECK: begin
          if (is_start) begin
            if (cur_ratio_r <= tol_r || up_proj_r == lo_proj_r) phase_r <= rfls_pkg::PH_IDLE;
          end else if (phase_r == rfls_pkg::PH_BRACKET) begin
            if (cur_ratio_r < tol_r) phase_r <= rfls_pkg::PH_IDLE;
          end else if (lo_proj_r == up_proj_r) begin
            step_r <= max_it_r;
          end
        end
        rfls_pkg::S_BRACKET: begin
          if (same_sign && can_grow) begin
            if (step_r != rfls_pkg::CNT_MAX) step_r <= step_r + 1'b1;
            up_eta_r  <= grown[EW-1:0];
            app_eta_r <= grown[EW-1:0];
            brk_r     <= brk_r + (grown[EW-1:0] - app_eta_r);
            phase_r   <= rfls_pkg::PH_BRACKET;
          end else if (same_sign) begin
            phase_r <= rfls_pkg::PH_IDLE;
          end else begin
            step_r <= '0;
          end
        end
        rfls_pkg::S_SECANT: begin
          if (!secant_go) begin
            phase_r <= rfls_pkg::PH_IDLE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        rfls_pkg::S_SDONE: begin
          if (eta_fin == app_eta_r) begin
            phase_r <= rfls_pkg::PH_IDLE;
          end else begin
            trial_eta_r <= eta_fin;
            phase_r     <= rfls_pkg::PH_SECANT;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_if.func;
      a_r    <= (in_if.func == rfls_pkg::FUNC_START) ? in_if.projection_full
                : in_if.projection_first;
      if (in_if.func == rfls_pkg::FUNC_FAIL) begin
        act_r <= in_if.fail_stage ? rfls_pkg::ACT_UNB_ERR : rfls_pkg::ACT_UPD_ERR;
        fac_r <= '0;
      end
    end
    unique case (state_r)
      rfls_pkg::S_CHECK: begin
        if (is_start) begin
          act_r <= rfls_pkg::ACT_UNCHANGED;
          fac_r <= rfls_pkg::ETA_ONE;
        end else begin
          act_r <= rfls_pkg::ACT_FINAL;
          fac_r <= app_eta_r;
        end
      end
      rfls_pkg::S_BRACKET: begin
        if (can_grow) begin
          act_r <= rfls_pkg::ACT_TRIAL;
          fac_r <= grown[EW-1:0] - app_eta_r;
        end else begin
          act_r <= rfls_pkg::ACT_RESTORE;
          fac_r <= -brk_r;
        end
      end
      rfls_pkg::S_SECANT: begin
        act_r      <= rfls_pkg::ACT_FINAL;
        fac_r      <= app_eta_r;
        prod_r     <= rfls_pkg::DIV_W'(mag_up * deta_mag);
        den_r      <= den_val;
        den_zero_r <= (den_val == '0);
        neg_r      <= up_proj_r[PW-1] ^ deta[EW] ^ (lo_proj_r < up_proj_r);
      end
      rfls_pkg::S_SDONE: begin
        if (eta_fin == app_eta_r) begin
          act_r <= rfls_pkg::ACT_FINAL;
          fac_r <= app_eta_r;
        end else begin
          act_r <= rfls_pkg::ACT_TRIAL;
          fac_r <= eta_fin - app_eta_r;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_act_r   <= act_r;
      out_fac_r   <= fac_r;
      out_ratio_r <= cur_ratio_r;
      out_cnt_r   <= step_r;
    end
  end

  assign in_if.ready           = in_ready;
  assign out_if.valid          = out_valid_r;
  assign out_if.action         = out_act_r;
  assign out_if.step_factor    = out_fac_r;
  assign out_if.residual_ratio = out_ratio_r;
  assign out_if.iteration      = out_cnt_r;
endmodule
`default_nettype wire

// ===== rtl/rfls_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module rfls_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [rfls_pkg::DIV_W-1:0]   dividend,
  input  wire logic [rfls_pkg::DEN_W-1:0]   divisor,
  output logic                              done,
  output logic [rfls_pkg::DIV_W-1:0]        quotient
);
  logic                            busy_r, busy_nxt;
  logic [rfls_pkg::DCNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rfls_pkg::DIV_W-1:0]      q_r, q_nxt;
  logic [rfls_pkg::DEN_W:0]        rem_r, rem_nxt;
  logic [rfls_pkg::DEN_W-1:0]      den_r;
  logic [rfls_pkg::DEN_W:0]        shifted;
  logic                            done_r, done_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[rfls_pkg::DEN_W-1:0], q_r[rfls_pkg::DIV_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rfls_pkg::DCNT_W'(rfls_pkg::DIV_W - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt = {q_r[rfls_pkg::DIV_W-2:0], 1'b0};
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt  = shifted - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = shifted;
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire
